### rtl/core/assert_macros.svh
// Assertion helpers for the RTL. Each use samples on clk and is
// disabled while rst_n is low, so the enclosing module must have both.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, prop, msg)

`endif

`endif

### rtl/core/fadd_pkg.sv
package fadd_pkg;

    // Input width; derived result and counter widths.
    localparam int IN_WIDTH = 16;
    localparam int NUM_W    = 2 * IN_WIDTH + 1;
    localparam int DEN_W    = 2 * IN_WIDTH;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    // Operand pair routed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_AD = 3'b001,
        MUL_BC = 3'b010,
        MUL_BD = 3'b100
    } mul_sel_t;

    // Operand pair routed to the shared divider.
    typedef enum logic [2:0] {
        DIV_EUCLID = 3'b001,
        DIV_NUM    = 3'b010,
        DIV_DEN    = 3'b100
    } div_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     sum_en;
        logic     euc_init;
        logic     div_start;
        div_src_t div_src;
        logic     euc_step;
        logic     qnum_en;
        logic     finish;
        logic     finish_err;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic y_zero;
        logic x_zero;
        logic div_done;
    } status_t;

endpackage

### rtl/core/fadd_div.sv
module fadd_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [fadd_pkg::NUM_W-1:0]  dividend,
    input  logic signed [fadd_pkg::NUM_W-1:0]  divisor,
    output logic                               done,
    output logic signed [fadd_pkg::NUM_W-1:0]  quotient,
    output logic signed [fadd_pkg::NUM_W-1:0]  remainder
);
    import fadd_pkg::*;

    logic [NUM_W-1:0] dvd_mag;
    logic [NUM_W-1:0] dvs_mag;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvs_reg;
    logic             qneg_reg;
    logic             rneg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;

    // Magnitudes of the operands; the most negative value maps to its
    // unsigned magnitude, which still fits in NUM_W bits.
    assign dvd_mag = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign dvs_mag = divisor[NUM_W-1]  ? (~divisor + 1'b1)  : divisor;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control: a pass is NUM_W steps, followed by a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else begin
            done_reg <= active_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(NUM_W);
            end
            else if (active_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg  <= dvd_mag;
            rem_reg  <= '0;
            dvs_reg  <= dvs_mag;
            qneg_reg <= dividend[NUM_W-1] ^ divisor[NUM_W-1];
            rneg_reg <= dividend[NUM_W-1];
        end
        else if (active_reg) begin
            if (!diff[NUM_W]) begin
                rem_reg <= diff[NUM_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else begin
                rem_reg <= shifted[NUM_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Truncating division: quotient sign is the XOR of the operand signs,
    // remainder takes the sign of the dividend.
    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign done      = done_reg;

endmodule

### rtl/core/fadd_dp.sv
module fadd_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fadd_pkg::cmd_t                       cmd,
    output fadd_pkg::status_t                    status,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] num_first,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] den_first,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] num_second,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] den_second,
    output logic signed [fadd_pkg::NUM_W-1:0]    sum_num,
    output logic signed [fadd_pkg::DEN_W-1:0]    sum_den,
    output logic                                 zero_div_error,
    output logic                                 done
);
    import fadd_pkg::*;

    logic signed [IN_WIDTH-1:0] a_reg;
    logic signed [IN_WIDTH-1:0] b_reg;
    logic signed [IN_WIDTH-1:0] c_reg;
    logic signed [IN_WIDTH-1:0] d_reg;
    logic signed [IN_WIDTH-1:0] mul_a;
    logic signed [IN_WIDTH-1:0] mul_b;
    logic signed [DEN_W-1:0]    prod_reg;
    logic signed [DEN_W-1:0]    acc_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [DEN_W-1:0]    den_reg;
    logic signed [NUM_W-1:0]    x_reg;
    logic signed [NUM_W-1:0]    y_reg;
    logic signed [NUM_W-1:0]    qnum_reg;
    logic signed [NUM_W-1:0]    sum_num_reg;
    logic signed [DEN_W-1:0]    sum_den_reg;
    logic                       err_reg;
    logic                       done_reg;
    logic signed [NUM_W-1:0]    div_dvd;
    logic signed [NUM_W-1:0]    div_dvs;
    logic                       div_done;
    logic signed [NUM_W-1:0]    div_q;
    logic signed [NUM_W-1:0]    div_r;

    // Operand capture when a transaction is accepted.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            a_reg <= num_first;
            b_reg <= den_first;
            c_reg <= num_second;
            d_reg <= den_second;
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_AD:  begin mul_a = a_reg; mul_b = d_reg; end
            MUL_BC:  begin mul_a = b_reg; mul_b = c_reg; end
            MUL_BD:  begin mul_a = b_reg; mul_b = d_reg; end
            default: begin mul_a = b_reg; mul_b = d_reg; end
        endcase
    end

    // Products, numerator sum, denominator, the Euclid pair and the numerator quotient.
    always_ff @(posedge clk) begin
        if (cmd.mul_en) begin
            prod_reg <= DEN_W'(mul_a) * DEN_W'(mul_b);
        end
        if (cmd.acc_en) begin
            acc_reg <= prod_reg;
        end
        if (cmd.sum_en) begin
            num_reg <= NUM_W'(acc_reg) + NUM_W'(prod_reg);
        end
        if (cmd.euc_init) begin
            den_reg <= prod_reg;
            x_reg   <= num_reg;
            y_reg   <= NUM_W'(prod_reg);
        end
        else if (cmd.euc_step) begin
            x_reg <= y_reg;
            y_reg <= div_r;
        end
        if (cmd.qnum_en) begin
            qnum_reg <= div_q;
        end
    end

    // Divider operand selection.
    always_comb begin
        unique case (cmd.div_src)
            DIV_EUCLID: begin div_dvd = x_reg;            div_dvs = y_reg; end
            DIV_NUM:    begin div_dvd = num_reg;          div_dvs = x_reg; end
            DIV_DEN:    begin div_dvd = NUM_W'(den_reg);  div_dvs = x_reg; end
            default:    begin div_dvd = x_reg;            div_dvs = y_reg; end
        endcase
    end

    fadd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Result registers and the one-cycle strobe.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= cmd.finish || cmd.finish_err;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.finish_err) begin
            sum_num_reg <= '0;
            sum_den_reg <= '0;
            err_reg     <= 1'b1;
        end
        else if (cmd.finish) begin
            sum_num_reg <= qnum_reg;
            sum_den_reg <= div_q[DEN_W-1:0];
            err_reg     <= 1'b0;
        end
    end

    assign status.y_zero   = (y_reg == '0);
    assign status.x_zero   = (x_reg == '0);
    assign status.div_done = div_done;

    assign sum_num        = sum_num_reg;
    assign sum_den        = sum_den_reg;
    assign zero_div_error = err_reg;
    assign done           = done_reg;

endmodule

### rtl/core/fadd_ctrl.sv
module fadd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output fadd_pkg::cmd_t    cmd,
    input  fadd_pkg::status_t status
);
    import fadd_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_MUL_AD   = 10'b00_0000_0010,
        ST_MUL_BC   = 10'b00_0000_0100,
        ST_MUL_BD   = 10'b00_0000_1000,
        ST_INIT     = 10'b00_0001_0000,
        ST_TEST     = 10'b00_0010_0000,
        ST_EUC_WAIT = 10'b00_0100_0000,
        ST_NUM_WAIT = 10'b00_1000_0000,
        ST_DEN_WAIT = 10'b01_0000_0000,
        ST_SPARE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Three products, numerator sum, Euclid loop, two divisions or error.
    always_comb begin
        cmd        = '0;
        cmd.mul_sel = MUL_AD;
        cmd.div_src = DIV_EUCLID;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_AD;
                end
            end
            ST_MUL_AD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AD;
                state_next  = ST_MUL_BC;
            end
            ST_MUL_BC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BC;
                cmd.acc_en  = 1'b1;
                state_next  = ST_MUL_BD;
            end
            ST_MUL_BD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BD;
                cmd.sum_en  = 1'b1;
                state_next  = ST_INIT;
            end
            ST_INIT: begin
                cmd.euc_init = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                if (!status.y_zero) begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_EUCLID;
                    state_next    = ST_EUC_WAIT;
                end
                else if (status.x_zero) begin
                    cmd.finish_err = 1'b1;
                    state_next     = ST_IDLE;
                end
                else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_NUM;
                    state_next    = ST_NUM_WAIT;
                end
            end
            ST_EUC_WAIT: begin
                if (status.div_done) begin
                    cmd.euc_step = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_NUM_WAIT: begin
                cmd.div_src = DIV_DEN;
                if (status.div_done) begin
                    cmd.qnum_en   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DEN_WAIT;
                end
            end
            ST_DEN_WAIT: begin
                if (status.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/core/fraction_add_reduce.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+------------------------
// input     | num_first, den_first, num_second, den_second       | start high, busy low
// result    | sum_num, sum_den, zero_div_error                   | done, one cycle
//
// A transaction runs from the accepting edge to the edge that takes the result
// through k Euclid remainder steps (up to about 45); each step is one 33-step
// pass of the shared radix-2 divider plus a handoff through the test state, and
// the final reduction takes two more passes. When numerator and denominator are
// both zero, no step runs and the error result follows without any division.
// busy stays high from acceptance until the result is issued; reset clears the
// controller and the strobe. The receiver cannot stall: done is high for exactly
// one cycle per transaction.
`include "assert_macros.svh"

module fraction_add_reduce (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] num_first,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] den_first,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] num_second,
    input  logic signed [fadd_pkg::IN_WIDTH-1:0] den_second,
    output logic                                 done,
    output logic signed [fadd_pkg::NUM_W-1:0]    sum_num,
    output logic signed [fadd_pkg::DEN_W-1:0]    sum_den,
    output logic                                 zero_div_error
);
    import fadd_pkg::*;

    cmd_t    cmd;
    status_t status;

    fadd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    fadd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .num_first      (num_first),
        .den_first      (den_first),
        .num_second     (num_second),
        .den_second     (den_second),
        .sum_num        (sum_num),
        .sum_den        (sum_den),
        .zero_div_error (zero_div_error),
        .done           (done)
    );

    // An accepted transaction keeps the block busy in the next cycle.
    `ASSERT_PROP(a_busy_after_accept, (start && !busy) |=> busy,
                 "block not busy after accepting a transaction")

    // A result is only issued at the end of a busy period.
    `ASSERT_PROP(a_done_after_busy, done |-> $past(busy),
                 "result strobe without a transaction in flight")

    // The error result is always 0/0.
    `ASSERT_PROP(a_err_zero, (done && zero_div_error) |-> (sum_num == '0 && sum_den == '0),
                 "error result is not zero over zero")

    // A normal result is never 0/0.
    `ASSERT_NEVER(a_ok_nonzero, done && !zero_div_error && sum_num == '0 && sum_den == '0,
                  "normal result reduced to zero over zero")

endmodule
